// File: sv/dtv_pkg.sv
// ----------------------------------------------------------------------------
// dtv_pkg
// Shared types, constants and rounding helpers for the time value converter.
// ----------------------------------------------------------------------------
package dtv_pkg;

    typedef struct packed {
        logic         dir;
        logic         flag;
        logic         neg;
        logic [31:0]  sec;
        logic [107:0] val;
        logic [6:0]   lead;
        logic [63:0]  word;
    } item_t;

    localparam logic        DIR_TO_TIMEVAL = 1'b0;
    localparam logic        DIR_TO_DOUBLE  = 1'b1;

    localparam logic [13:0] FRAC_K   = 14'd15625;
    localparam logic [52:0] MICRO_M  = 53'h10C6F7A0B5ED8D;
    localparam logic [26:0] MICRO_LO = MICRO_M[26:0];
    localparam logic [25:0] MICRO_HI = MICRO_M[52:27];
    localparam logic [10:0] EXP_FRAC = 11'd1002;
    localparam logic [10:0] EXP_TOP  = 11'd1054;
    localparam logic [10:0] EXP_BIAS = 11'd951;

    function automatic logic [6:0] lead_one(input logic [107:0] v);
        logic [6:0] pos;
        pos = 7'd0;
        for (int i = 0; i < 108; i++) begin
            if (v[i]) begin
                pos = 7'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [107:0] round53(input logic [107:0] v, input logic [6:0] l);
        logic [6:0]   sh;
        logic [107:0] unit;
        logic [107:0] mask;
        logic [107:0] low;
        logic [107:0] half;
        logic [107:0] res;
        res  = v;
        sh   = 7'd0;
        unit = 108'd0;
        mask = 108'd0;
        low  = 108'd0;
        half = 108'd0;
        if (l > 7'd52) begin
            sh   = l - 7'd52;
            unit = 108'd1 << sh;
            mask = unit - 108'd1;
            low  = v & mask;
            half = unit >> 1;
            res  = v & ~mask;
            if (low > half || (low == half && v[sh])) begin
                res = res + unit;
            end
        end
        return res;
    endfunction

endpackage

// File: sv/dtv_front.sv
// ----------------------------------------------------------------------------
// dtv_front
// Decode the input word, form the partial products and sum them (3 stages).
// ----------------------------------------------------------------------------
module dtv_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  logic           dir_i,
    input  logic [63:0]    word_i,
    output logic           vld_o,
    output dtv_pkg::item_t item_o
);
    import dtv_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    item_t       s1_reg, s1_next, s2_reg, s3_reg, s3_next;
    logic [58:0] p0_reg, p1_reg, p2_reg, p0_next, p1_next, p2_next;

    always_comb begin
        logic        sgn;
        logic [10:0] ef;
        logic [52:0] m;
        logic        inr;
        logic [5:0]  sh;
        logic [104:0] x;
        logic [31:0] ip;
        logic [31:0] mag;
        sgn = word_i[63];
        ef  = word_i[62:52];
        m   = {ef != 11'd0, word_i[51:0]};
        inr = (ef < EXP_TOP) || (ef == EXP_TOP && sgn && word_i[51:21] == 31'd0);
        sh  = 6'(ef - EXP_FRAC);
        x   = (inr && ef >= EXP_FRAC) ? ({52'd0, m} << sh) : 105'd0;
        ip  = x[104:73];
        mag = word_i[31] ? (~word_i[31:0] + 32'd1) : word_i[31:0];
        s1_next      = '0;
        s1_next.dir  = dir_i;
        if (dir_i == DIR_TO_TIMEVAL) begin
            s1_next.flag = ~inr;
            s1_next.neg  = sgn;
            s1_next.sec  = sgn ? (~ip + 32'd1) : ip;
            s1_next.val  = {35'd0, x[72:0]};
        end else begin
            s1_next.neg  = word_i[31];
            s1_next.sec  = word_i[63:32];
            s1_next.val  = {76'd0, mag};
        end
    end

    always_comb begin
        logic [38:0] a0, a1, a2;
        logic [58:0] b0;
        logic [57:0] b1;
        a0 = s1_reg.val[24:0] * FRAC_K;
        a1 = s1_reg.val[49:25] * FRAC_K;
        a2 = {2'd0, s1_reg.val[72:50]} * FRAC_K;
        b0 = s1_reg.val[31:0] * MICRO_LO;
        b1 = s1_reg.val[31:0] * MICRO_HI;
        if (s1_reg.dir == DIR_TO_TIMEVAL) begin
            p0_next = {20'd0, a0};
            p1_next = {20'd0, a1};
            p2_next = {20'd0, a2};
        end else begin
            p0_next = b0;
            p1_next = {1'b0, b1};
            p2_next = 59'd0;
        end
    end

    always_comb begin
        logic [107:0] e0, e1, e2;
        e0 = {49'd0, p0_reg};
        e1 = {49'd0, p1_reg};
        e2 = {49'd0, p2_reg};
        s3_next = s2_reg;
        if (s2_reg.dir == DIR_TO_TIMEVAL) begin
            s3_next.val = (e0 + (e1 << 25) + (e2 << 50)) << 6;
        end else begin
            s3_next.val = e0 + (e1 << 27);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vld_i;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            s3_reg <= s3_next;
        end
    end

    assign vld_o  = v3_reg;
    assign item_o = s3_reg;

endmodule

// File: sv/dtv_round.sv
// ----------------------------------------------------------------------------
// dtv_round
// Find the leading one, then round to 53 significant bits, ties to even.
// ----------------------------------------------------------------------------
module dtv_round (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  dtv_pkg::item_t item_i,
    output logic           vld_o,
    output dtv_pkg::item_t item_o
);
    import dtv_pkg::*;

    logic  va_reg, vb_reg;
    item_t sa_reg, sa_next, sb_reg, sb_next;

    always_comb begin
        sa_next      = item_i;
        sa_next.lead = lead_one(item_i.val);
        sb_next      = sa_reg;
        sb_next.val  = round53(sa_reg.val, sa_reg.lead);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= vld_i;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
        end
    end

    assign vld_o  = vb_reg;
    assign item_o = sb_reg;

endmodule

// File: sv/dtv_merge.sv
// ----------------------------------------------------------------------------
// dtv_merge
// Finish the timeval word, or add the seconds to the scaled microseconds.
// ----------------------------------------------------------------------------
module dtv_merge (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  dtv_pkg::item_t item_i,
    output logic           vld_o,
    output dtv_pkg::item_t item_o
);
    import dtv_pkg::*;

    logic  v_reg;
    item_t s_reg, s_next;

    always_comb begin
        logic [20:0]  u;
        logic [31:0]  u32;
        logic [31:0]  usec;
        logic [107:0] sv;
        logic [107:0] q;
        logic [107:0] sum;
        u    = {1'b0, item_i.val[92:73]} + {20'd0, item_i.val[72]};
        u32  = {11'd0, u};
        usec = item_i.neg ? (~u32 + 32'd1) : u32;
        sv   = {{4{item_i.sec[31]}}, item_i.sec, 72'd0};
        q    = item_i.neg ? (~item_i.val + 108'd1) : item_i.val;
        sum  = sv + q;
        s_next = item_i;
        if (item_i.dir == DIR_TO_TIMEVAL) begin
            s_next.word = item_i.flag ? 64'd0 : {item_i.sec, usec};
            s_next.val  = 108'd0;
        end else begin
            s_next.neg  = sum[107];
            s_next.val  = sum[107] ? (~sum + 108'd1) : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
        end
    end

    assign vld_o  = v_reg;
    assign item_o = s_reg;

endmodule

// File: sv/dtv_pack.sv
// ----------------------------------------------------------------------------
// dtv_pack
// Pack the rounded sum into a double, and hold the output word.
// ----------------------------------------------------------------------------
module dtv_pack (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_i,
    input  dtv_pkg::item_t item_i,
    output logic           vld_o,
    output logic [63:0]    word_o,
    output logic           flag_o
);
    import dtv_pkg::*;

    logic        v_reg;
    logic [63:0] word_reg, word_next;
    logic        flag_reg, flag_next;

    always_comb begin
        logic [107:0] hi;
        logic [6:0]   l2;
        logic [107:0] sm;
        logic [10:0]  ex;
        hi = item_i.val >> item_i.lead;
        l2 = item_i.lead + {6'd0, hi[1]};
        sm = (l2 >= 7'd52) ? (item_i.val >> (l2 - 7'd52)) : (item_i.val << (7'd52 - l2));
        ex = {4'd0, l2} + EXP_BIAS;
        flag_next = 1'b0;
        if (item_i.dir == DIR_TO_TIMEVAL) begin
            word_next = item_i.word;
            flag_next = item_i.flag;
        end else if (item_i.val == 108'd0) begin
            word_next = 64'd0;
        end else begin
            word_next = {item_i.neg, ex, sm[51:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= vld_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
            flag_reg <= flag_next;
        end
    end

    assign vld_o  = v_reg;
    assign word_o = word_reg;
    assign flag_o = flag_reg;

endmodule

// File: sv/double_timeval_converter.sv
// ----------------------------------------------------------------------------
// double_timeval_converter
// Converts 64-bit words between IEEE double seconds and packed
// seconds:microseconds, in the direction held by the configuration register.
// ----------------------------------------------------------------------------
//  channel | ports                              | word
//  cfg     | cfg_valid cfg_ready cfg_direction  | 0: double to timeval, 1: back
//  input   | s_valid s_ready s_word_in          | one 64-bit word
//  output  | m_valid m_ready m_word_out         | result word and range flag
//          | m_out_of_range                     |
//
// Nine register stages: one word per cycle while m_ready does not stall the output.
// The depth comes from the two lead-and-round passes and the split products.
// Reset clears the stage valid bits and the direction register.
// A stall on m_ready holds every stage in place; the output register holds.
// ----------------------------------------------------------------------------
module double_timeval_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_direction,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_word_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_word_out,
    output logic        m_out_of_range
);
    import dtv_pkg::*;

    logic  dir_reg;
    logic  en;
    logic  f_vld, r1_vld, mg_vld, r2_vld;
    item_t f_item, r1_item, mg_item, r2_item;

    assign en        = ~m_valid | m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg <= DIR_TO_TIMEVAL;
        end else if (cfg_valid) begin
            dir_reg <= cfg_direction;
        end
    end

    dtv_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (s_valid),
        .dir_i   (dir_reg),
        .word_i  (s_word_in),
        .vld_o   (f_vld),
        .item_o  (f_item)
    );

    dtv_round u_round_prod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (f_vld),
        .item_i  (f_item),
        .vld_o   (r1_vld),
        .item_o  (r1_item)
    );

    dtv_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (r1_vld),
        .item_i  (r1_item),
        .vld_o   (mg_vld),
        .item_o  (mg_item)
    );

    dtv_round u_round_sum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (mg_vld),
        .item_i  (mg_item),
        .vld_o   (r2_vld),
        .item_o  (r2_item)
    );

    dtv_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_i   (r2_vld),
        .item_i  (r2_item),
        .vld_o   (m_valid),
        .word_o  (m_word_out),
        .flag_o  (m_out_of_range)
    );

endmodule

// File: sim/dtv_checker.sv
// ----------------------------------------------------------------------------
// dtv_checker
// Watches the configuration, input and result channels of the time value
// converter. Predicts each result word from the accepted input word and the
// current direction, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module dtv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_direction,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_word_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_word_out,
    input  logic        m_out_of_range,
    output int          errors,
    output int          pending
);
    import dtv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] word;
        logic        flag;
    } conv_t;

    logic  direction;
    conv_t conv_q[$];

    function automatic conv_t convert(input logic dir, input logic [63:0] w);
        conv_t       c;
        real         secs;
        real         scaled;
        real         rest;
        int          whole;
        int          micro;
        logic [31:0] hi;
        logic [31:0] lo;
        c.word = '0;
        c.flag = 1'b0;
        if (dir == DIR_TO_TIMEVAL) begin
            secs = $bitstoreal(w);
            if (!(secs > -2147483649.0 && secs < 2147483648.0)) begin
                c.flag = 1'b1;
            end else begin
                whole  = $rtoi(secs);
                scaled = (secs - real'(whole)) * 1.0e6;
                micro  = $rtoi(scaled);
                rest   = scaled - real'(micro);
                if (rest >= 0.5) begin
                    micro = micro + 1;
                end else if (rest <= -0.5) begin
                    micro = micro - 1;
                end
                hi = whole;
                lo = micro;
                c.word = {hi, lo};
            end
        end else begin
            c.word = $realtobits(1.0e-6 * real'($signed(w[31:0])) +
                                 real'($signed(w[63:32])));
        end
        return c;
    endfunction

    always @(posedge aclk) begin
        conv_t e;
        int    bad;
        bad = 0;
        if (!aresetn) begin
            direction <= DIR_TO_TIMEVAL;
            conv_q.delete();
            errors <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                direction <= cfg_direction;
            end
            if (s_valid && s_ready) begin
                conv_q.push_back(convert(direction, s_word_in));
            end
            if (m_valid && m_ready) begin
                if (conv_q.size() == 0) begin
                    $error("result word 0x%h with none expected", m_word_out);
                    bad = bad + 1;
                end else begin
                    e = conv_q.pop_front();
                    if (m_word_out !== e.word) begin
                        $error("word_out: expected 0x%h, got 0x%h", e.word, m_word_out);
                        bad = bad + 1;
                    end
                    if (m_out_of_range !== e.flag) begin
                        $error("out_of_range: expected %0b, got %0b", e.flag,
                               m_out_of_range);
                        bad = bad + 1;
                    end
                end
            end
            errors <= errors + bad;
            pending <= conv_q.size();
        end
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the double / timeval converter: directed corner words in both
// directions, then random phases that alternate the direction register, with
// random gaps on the input and stalls on the output in all but the last phase.
// ----------------------------------------------------------------------------
module tb;
    import dtv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_direction;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_word_in;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_word_out;
    logic        m_out_of_range;
    int          errors;
    int          pending;
    bit          calm;
    int          stall_left;
    int          n_words;
    int          n_writes;

    double_timeval_converter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_direction  (cfg_direction),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word_in      (s_word_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word_out     (m_word_out),
        .m_out_of_range (m_out_of_range)
    );

    dtv_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_direction  (cfg_direction),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_word_in      (s_word_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word_out     (m_word_out),
        .m_out_of_range (m_out_of_range),
        .errors         (errors),
        .pending        (pending)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

    always @(negedge aclk) begin
        if (calm || !aresetn) begin
            m_ready = 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    task automatic drain();
        wait (pending == 0);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_direction(input logic dir);
        drain();
        cfg_valid = 1'b1;
        cfg_direction = dir;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        n_writes++;
    endtask

    task automatic send_word(input logic [63:0] w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_word_in = w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        n_words++;
    endtask

    function automatic logic [63:0] rand_double();
        logic [51:0] frac;
        logic        sign;
        real         whole;
        frac = 52'({$urandom, $urandom});
        sign = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: return {$urandom, $urandom};
            1: return {sign, 11'($urandom_range(990, 1075)), frac};
            2: begin
                whole = real'($urandom_range(0, 32'h7fffffff));
                whole = whole + real'(2 * $urandom_range(0, 63) + 1) / 128.0;
                return $realtobits(sign ? -whole : whole);
            end
            3: return {sign, 11'($urandom_range(1052, 1054)), frac};
            default: return {sign, 11'($urandom_range(1020, 1040)), frac};
        endcase
    endfunction

    function automatic logic [63:0] rand_timeval();
        logic [31:0] usec;
        if ($urandom_range(0, 3) == 0) begin
            usec = $urandom;
        end else begin
            usec = $urandom_range(0, 2000000) - 1000000;
        end
        return {32'($urandom), usec};
    endfunction

    initial begin
        logic [63:0] fwd_list[$];
        logic [63:0] rev_list[$];
        logic        dir;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_direction = DIR_TO_TIMEVAL;
        s_valid = 1'b0;
        s_word_in = '0;
        m_ready = 1'b1;
        calm = 1'b0;
        stall_left = 0;
        n_words = 0;
        n_writes = 0;
        fwd_list = '{64'h0000000000000000, 64'h8000000000000000,
                     64'h7ff0000000000000, 64'hfff0000000000000,
                     64'h7ff8000000000000, 64'hffffffffffffffff,
                     64'h0000000000000001, 64'h3f80000000000000,
                     64'hbf80000000000000, 64'h41dfffffffffffff,
                     64'h41e0000000000000, 64'hc1e0000000000000,
                     64'hc1e0000000200000, 64'hc1e0000000100000,
                     64'h3ff8000000000000, 64'h3fefffffffffffff,
                     64'h3eb0c6f7a0b5ed8d, 64'h3ea0c6f7a0b5ed8d};
        rev_list = '{64'h0000000000000000, 64'hffffffffffffffff,
                     64'h7fffffff7fffffff, 64'h8000000080000000,
                     64'h00000001fff0bdc0, 64'h80000000000f4240};
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        write_direction(DIR_TO_TIMEVAL);
        foreach (fwd_list[i]) send_word(fwd_list[i]);
        write_direction(DIR_TO_DOUBLE);
        foreach (rev_list[i]) send_word(rev_list[i]);

        for (int p = 0; p < 5; p++) begin
            dir = (p % 2 == 0) ? DIR_TO_TIMEVAL : DIR_TO_DOUBLE;
            calm = (p == 4);
            write_direction(dir);
            for (int k = 0; k < (calm ? 150 : 400); k++) begin
                if (p == 1 && k == 200) begin
                    wait (pending == 0);
                    @(negedge aclk);
                end
                send_word(dir == DIR_TO_TIMEVAL ? rand_double() : rand_timeval());
            end
        end

        wait (pending == 0);
        repeat (20) @(posedge aclk);
        $display("Sent %0d words over %0d direction writes, both directions,", n_words,
                 n_writes);
        $display("including NaN, infinities, range edges and half-microsecond ties.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
